[src/dcc_pkg.sv]
// Package for the DCC bit generator: frame phase codes, request codes and encodings.
package dcc_pkg;

    // Ones sent ahead of the first start bit of every frame
    localparam int PREAMBLE_ONES = 14;

    // Frame phase counter: idle, preamble counts, start bit, data bits, closing one
    localparam int PHASE_W = $clog2(PREAMBLE_ONES + 3);
    typedef logic [PHASE_W-1:0] phase_t;

    localparam phase_t PH_IDLE  = PHASE_W'(0);
    localparam phase_t PH_START = PHASE_W'(PREAMBLE_ONES);
    localparam phase_t PH_BYTE  = PHASE_W'(PREAMBLE_ONES + 1);
    localparam phase_t PH_END   = PHASE_W'(PREAMBLE_ONES + 2);

    // Request kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_RAW  = 2'd1,
        OP_ACC  = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic CFG_ONE_HALF  = 1'b0;
    localparam logic CFG_ZERO_HALF = 1'b1;

    localparam logic [7:0] ONE_HALF_RESET  = 8'd115;
    localparam logic [7:0] ZERO_HALF_RESET = 8'd199;

    // Idle packet bytes
    localparam logic [7:0] IDLE_BYTE0 = 8'hFF;
    localparam logic [7:0] IDLE_BYTE1 = 8'h00;
    localparam logic [7:0] IDLE_BYTE2 = 8'hFF;

    localparam logic [7:0] BIT_SEL_MSB = 8'h80;

    // Basic accessory packet, first byte: 10AAAAAA from address bits 7..2
    function automatic logic [7:0] acc_byte0(input logic [10:0] addr);
        acc_byte0 = {2'b10, addr[7:2]};
    endfunction

    // Second byte: 1aaa1PPO, aaa the inverted address bits 10..8
    function automatic logic [7:0] acc_byte1(input logic [10:0] addr, input logic outb);
        acc_byte1 = {1'b1, ~addr[10:8], 1'b1, addr[1:0], outb};
    endfunction

endpackage

[src/dcc_packet_bit_generator.sv]
// DCC packet bit generator: one track bit per tick request, with a one-deep packet queue.
// Result: registered, and shown on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register is refilled while
//   being drained, and s_tready drops only while an untaken result stalls.
// Reset: asynchronous, active low; frame at the idle phase, queue empty, half periods
//   at 115 and 199. Packet byte stores are not cleared and are always written before use.
module dcc_packet_bit_generator
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: byte_first[7:0], byte_second[15:8], accessory_address[26:16],
    //          output_bit[27], repeat_count[35:28], zero fill[39:36]
    input  logic [39:0] s_tdata,
    // s_tuser: op[1:0]
    input  logic [1:0]  s_tuser,
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: bit_value[0], half_period[8:1], load_accepted[9], pending_empty[10],
    //          zero fill[15:11]
    output logic [15:0] m_tdata,
    // m_tuser: bit_valid[0]
    output logic [0:0]  m_tuser
);

    import dcc_pkg::*;

    // Configuration
    logic [7:0] one_half_reg;
    logic [7:0] zero_half_reg;

    // Frame state
    phase_t     phase_reg,      phase_next;
    logic [7:0] bit_sel_reg,    bit_sel_next;
    logic [1:0] byte_pos_reg,   byte_pos_next;
    logic [7:0] shift_reg,      shift_next;
    logic [7:0] active_reg [3];
    logic [7:0] active_next [3];
    logic       active_we;

    // Queue
    logic [7:0] pend0_reg,      pend0_next;
    logic [7:0] pend1_reg,      pend1_next;
    logic [7:0] repeats_reg,    repeats_next;
    logic       pend_we;

    // Result register
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic        m_user_reg;

    // Request fields
    logic [1:0]  op;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [10:0] acc_addr;
    logic        out_bit;
    logic [7:0]  rep_count;

    logic        accept;
    logic        res_bit_valid;
    logic        res_bit;
    logic [7:0]  res_half;
    logic        res_accepted;
    logic [1:0]  pos_inc;
    logic [7:0]  sel_shifted;

    assign op          = s_tuser;
    assign byte_first  = s_tdata[7:0];
    assign byte_second = s_tdata[15:8];
    assign acc_addr    = s_tdata[26:16];
    assign out_bit     = s_tdata[27];
    assign rep_count   = s_tdata[35:28];

    // Take a new request whenever the result register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_inc     = byte_pos_reg + 2'd1;
    assign sel_shifted = bit_sel_reg >> 1;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_sel_next   = bit_sel_reg;
        byte_pos_next  = byte_pos_reg;
        shift_next     = shift_reg;
        active_next[0] = active_reg[0];
        active_next[1] = active_reg[1];
        active_next[2] = active_reg[2];
        active_we      = 1'b0;
        pend0_next     = pend0_reg;
        pend1_next     = pend1_reg;
        repeats_next   = repeats_reg;
        pend_we        = 1'b0;
        res_bit_valid  = 1'b0;
        res_bit        = 1'b0;
        res_accepted   = 1'b0;

        unique case (op)
            OP_TICK:
            begin
                res_bit_valid = 1'b1;
                res_bit       = 1'b1;
                if (phase_reg == PH_BYTE)
                begin
                    // Send the selected data bit, MSB first
                    res_bit      = |(shift_reg & bit_sel_reg);
                    bit_sel_next = sel_shifted;
                    if (sel_shifted == 8'd0)
                    begin
                        byte_pos_next = pos_inc;
                        phase_next    = (pos_inc != 2'd3) ? PH_START : PH_END;
                    end
                end
                else if (phase_reg == PH_START)
                begin
                    // Start bit; load the next packet byte into the shifter
                    res_bit      = 1'b0;
                    bit_sel_next = BIT_SEL_MSB;
                    case (byte_pos_reg)
                        2'd0:    shift_next = active_reg[0];
                        2'd1:    shift_next = active_reg[1];
                        2'd2:    shift_next = active_reg[2];
                        default: shift_next = 8'd0;
                    endcase
                    phase_next = PH_BYTE;
                end
                else if (phase_reg == PH_END)
                begin
                    phase_next = PH_IDLE;
                end
                else if (phase_reg == PH_IDLE)
                begin
                    // Open a frame: take the queued packet, else the idle packet
                    active_we = 1'b1;
                    if (repeats_reg != 8'd0)
                    begin
                        active_next[0] = pend0_reg;
                        active_next[1] = pend1_reg;
                        active_next[2] = pend0_reg ^ pend1_reg;
                        repeats_next   = repeats_reg - 8'd1;
                    end
                    else
                    begin
                        active_next[0] = IDLE_BYTE0;
                        active_next[1] = IDLE_BYTE1;
                        active_next[2] = IDLE_BYTE2;
                    end
                    byte_pos_next = 2'd0;
                    phase_next    = PHASE_W'(1);
                end
                else if (phase_reg < PH_START)
                begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            OP_RAW:
            begin
                if (repeats_reg == 8'd0)
                begin
                    res_accepted = 1'b1;
                    pend_we      = 1'b1;
                    pend0_next   = byte_first;
                    pend1_next   = byte_second;
                    repeats_next = 8'd1;
                end
            end
            OP_ACC:
            begin
                if (repeats_reg == 8'd0)
                begin
                    res_accepted = 1'b1;
                    pend_we      = 1'b1;
                    pend0_next   = acc_byte0(acc_addr);
                    pend1_next   = acc_byte1(acc_addr, out_bit);
                    repeats_next = rep_count;
                end
            end
            default:
            begin
                // Unused code: no operation
            end
        endcase

        res_half = 8'd0;
        if (res_bit_valid)
        begin
            res_half = res_bit ? one_half_reg : zero_half_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_half_reg  <= ONE_HALF_RESET;
            zero_half_reg <= ZERO_HALF_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ONE_HALF)
            begin
                one_half_reg <= cfg_data;
            end
            if (cfg_index == CFG_ZERO_HALF)
            begin
                zero_half_reg <= cfg_data;
            end
        end
    end

    // Frame and queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            bit_sel_reg  <= 8'd0;
            byte_pos_reg <= 2'd0;
            shift_reg    <= 8'd0;
            repeats_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            bit_sel_reg  <= bit_sel_next;
            byte_pos_reg <= byte_pos_next;
            shift_reg    <= shift_next;
            repeats_reg  <= repeats_next;
        end
    end

    // Packet byte stores: no reset, written before first use
    always_ff @(posedge clk)
    begin
        if (accept && active_we)
        begin
            active_reg[0] <= active_next[0];
            active_reg[1] <= active_next[1];
            active_reg[2] <= active_next[2];
        end
        if (accept && pend_we)
        begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
        end
    end

    // Result register: hold while stalled, refill on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= {5'd0, (repeats_next == 8'd0), res_accepted, res_half, res_bit};
            m_user_reg <= res_bit_valid;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

`ifndef SYNTH
    // A load arriving while the queue is occupied must be refused
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_RAW || op == OP_ACC) && repeats_reg != 8'd0)
        |=> (m_tdata[9] == 1'b0))
        else $error("load taken while queue busy");

    // Reported queue status matches the queue counter after each request
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (m_tdata[10] == (repeats_reg == 8'd0)))
        else $error("pending_empty disagrees with queue state");

    // The phase counter never leaves the frame's range
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_END)
        else $error("frame phase out of range");

    // While sending data bits a bit is always selected
    a_bit_select: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BYTE) |-> (bit_sel_reg != 8'd0))
        else $error("data phase with no bit selected");
`endif

endmodule
